### rtl/hdbn_pkg.sv
package hdbn_pkg;

    // field widths
    localparam int ORDER_W     = 4;
    localparam int SYM_W       = 2;
    localparam int ZRUN_W      = 4;

    // order register limits
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;
    localparam logic [ORDER_W-1:0] ORDER_MIN   = 4'd2;

    // delay line depth default
    localparam int MAX_ORDER_DEF = 8;

    // front-to-back queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [SYM_W-1:0] sym_t;

    localparam sym_t SYM_ZERO = 2'sb00;
    localparam sym_t SYM_POS  = 2'sb01;
    localparam sym_t SYM_NEG  = 2'sb11;

    localparam logic [ZRUN_W-1:0] ZRUN_MAX = '1;

    typedef enum logic
    {
        ACT_DATA  = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    typedef struct packed
    {
        logic action;
        logic data_bit;
    } in_item_t;

    typedef struct packed
    {
        sym_t symbol;
        logic last;
    } out_item_t;

    // classified word passed from front to back
    typedef struct packed
    {
        logic flush;
        sym_t cur;
        sym_t balance;
    } cmd_t;

endpackage

### rtl/hdbn_front.sv
module hdbn_front
    import hdbn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    input  logic [ORDER_W-1:0] order,
    output logic               push_valid,
    input  logic               push_ready,
    output cmd_t               push_cmd
);

    logic              last_mark_pos_reg,  last_mark_pos_next;
    logic              last_viol_pos_reg,  last_viol_pos_next;
    logic              first_pending_reg,  first_pending_next;
    logic [ZRUN_W-1:0] zrun_reg,           zrun_next;
    logic              accept;

    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;

    // polarity, zero run and violation decisions
    always_comb
    begin
        last_mark_pos_next = last_mark_pos_reg;
        last_viol_pos_next = last_viol_pos_reg;
        first_pending_next = first_pending_reg;
        zrun_next          = zrun_reg;
        push_cmd.flush     = 1'b0;
        push_cmd.cur       = SYM_ZERO;
        push_cmd.balance   = SYM_ZERO;

        if (action_t'(in_data.action) == ACT_FLUSH)
        begin
            push_cmd.flush     = 1'b1;
            last_mark_pos_next = 1'b1;
            last_viol_pos_next = 1'b0;
            first_pending_next = 1'b1;
            zrun_next          = '0;
        end
        else
        begin
            if (first_pending_reg && in_data.data_bit)
            begin
                push_cmd.cur = SYM_POS;
            end
            else if (!in_data.data_bit)
            begin
                if (zrun_reg != ZRUN_MAX)
                begin
                    zrun_next = zrun_reg + 1'b1;
                end
                push_cmd.cur = SYM_ZERO;
            end
            else
            begin
                zrun_next          = '0;
                last_mark_pos_next = !last_mark_pos_reg;
                push_cmd.cur       = last_mark_pos_reg ? SYM_NEG : SYM_POS;
            end
            first_pending_next = 1'b0;

            // substitution of a full zero run
            if ({1'b0, zrun_next} >= ({1'b0, order} + 1'b1))
            begin
                if (!last_viol_pos_reg)
                begin
                    if (!last_mark_pos_next)
                    begin
                        push_cmd.balance = SYM_POS;
                    end
                    push_cmd.cur       = SYM_POS;
                    last_mark_pos_next = 1'b1;
                    last_viol_pos_next = 1'b1;
                end
                else
                begin
                    if (last_mark_pos_next)
                    begin
                        push_cmd.balance = SYM_NEG;
                    end
                    push_cmd.cur       = SYM_NEG;
                    last_mark_pos_next = 1'b0;
                    last_viol_pos_next = 1'b0;
                end
                zrun_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mark_pos_reg <= 1'b1;
            last_viol_pos_reg <= 1'b0;
            first_pending_reg <= 1'b1;
            zrun_reg          <= '0;
        end
        else if (accept)
        begin
            last_mark_pos_reg <= last_mark_pos_next;
            last_viol_pos_reg <= last_viol_pos_next;
            first_pending_reg <= first_pending_next;
            zrun_reg          <= zrun_next;
        end
    end

endmodule

### rtl/hdbn_queue.sv
module hdbn_queue
    import hdbn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/hdbn_back.sv
module hdbn_back
    import hdbn_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ORDER_W-1:0] order,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  cmd_t               pop_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data
);

    localparam int FILL_W = $clog2(MAX_ORDER + 1);
    localparam int CW     = (FILL_W > ORDER_W) ? FILL_W : ORDER_W;

    sym_t              line_reg [MAX_ORDER];
    sym_t              line_next[MAX_ORDER];
    sym_t              eff      [MAX_ORDER];
    logic [FILL_W-1:0] fill_reg,      fill_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg,       out_next;
    logic [CW-1:0]     fill_ext;
    logic [CW-1:0]     n_ext;
    logic [CW-1:0]     bal_pos;
    logic              can_emit;
    logic              at_or_over;

    assign fill_ext   = CW'(fill_reg);
    assign n_ext      = CW'(order);
    assign bal_pos    = fill_ext - n_ext;
    assign at_or_over = (fill_ext >= n_ext);
    assign can_emit   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    // line with the balancing pulse applied (rewriting it each cycle is harmless)
    always_comb
    begin
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            if (!pop_cmd.flush && pop_cmd.balance != SYM_ZERO && at_or_over
                && bal_pos == CW'(i))
            begin
                eff[i] = pop_cmd.balance;
            end
            else
            begin
                eff[i] = line_reg[i];
            end
        end
    end

    // emission sequencer: one word per cycle from the head of the line while the output register is free
    always_comb
    begin
        line_next      = line_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        pop_ready      = 1'b0;

        if (pop_valid)
        begin
            if (pop_cmd.flush)
            begin
                if (fill_reg == '0)
                begin
                    pop_ready = 1'b1;
                end
                else if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_next.symbol = line_reg[0];
                    out_next.last   = (fill_reg == FILL_W'(1));
                    for (int i = 0; i < MAX_ORDER - 1; i++)
                    begin
                        line_next[i] = line_reg[i + 1];
                    end
                    line_next[MAX_ORDER - 1] = SYM_ZERO;
                    fill_next = fill_reg - 1'b1;
                    pop_ready = (fill_reg == FILL_W'(1));
                end
            end
            else if (!at_or_over)
            begin
                // line still filling: append only
                for (int i = 0; i < MAX_ORDER; i++)
                begin
                    if (fill_ext == CW'(i))
                    begin
                        line_next[i] = pop_cmd.cur;
                    end
                end
                fill_next = fill_reg + 1'b1;
                pop_ready = 1'b1;
            end
            else if (can_emit)
            begin
                out_valid_next  = 1'b1;
                out_next.symbol = eff[0];
                out_next.last   = 1'b0;
                for (int i = 0; i < MAX_ORDER - 1; i++)
                begin
                    line_next[i] = eff[i + 1];
                end
                line_next[MAX_ORDER - 1] = SYM_ZERO;
                if (fill_ext == n_ext)
                begin
                    // last pop of this word: new symbol goes in behind
                    for (int i = 0; i < MAX_ORDER; i++)
                    begin
                        if (fill_ext == CW'(i + 1))
                        begin
                            line_next[i] = pop_cmd.cur;
                        end
                    end
                    pop_ready = 1'b1;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                line_reg[i] <= SYM_ZERO;
            end
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            line_reg      <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

### rtl/hdbn_line_encoder.sv
// Channel  | Signals                     | Word
// ---------+-----------------------------+-------------------------------
// in       | in_valid / in_ready         | in_data  {action, data_bit}
// out      | out_valid / out_ready       | out_data {symbol, last}
// cfg      | cfg_valid / cfg_ready       | cfg_data hdb_order (clamped)
//
// One input word per cycle is taken while the two-entry command queue has room;
// symbols leave n words late, one per cycle from the output register unless the
// output stalls. A flush emits its k held symbols, last one marked; an order drop
// drains surplus first. The back end's single output register sets the rate.
// Reset (rst_n, async) empties the line and restores order 3 and +1 polarity.
// Output stalls back up through the queue to in_ready.
module hdbn_line_encoder
    import hdbn_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ORDER_W-1:0] cfg_data
);

    logic [ORDER_W-1:0] order_reg, order_next;
    logic               push_valid;
    logic               push_ready;
    cmd_t               push_cmd;
    logic               pop_valid;
    logic               pop_ready;
    cmd_t               pop_cmd;

    assign cfg_ready = 1'b1;

    // order register with clamping
    always_comb
    begin
        if (cfg_data < ORDER_MIN)
        begin
            order_next = ORDER_MIN;
        end
        else if ({1'b0, cfg_data} > (ORDER_W + 1)'(MAX_ORDER))
        begin
            order_next = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            order_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            order_reg <= order_next;
        end
    end

    hdbn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .order      (order_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    hdbn_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    hdbn_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .order      (order_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

### sim/hdbn_checker.sv
`timescale 1ns / 100ps

// Watches the in, out and cfg channels of the HDBn encoder, predicts the
// symbol stream and compares every output word against it.
module hdbn_checker
    import hdbn_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  out_item_t          out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [ORDER_W-1:0] cfg_data,
    output int                 err_count,
    output int                 due_count
);

    // shadow of the encoder state
    sym_t              line_q [MAX_ORDER];
    int                held;
    logic [ZRUN_W-1:0] zero_run;
    logic              mark_pos;
    logic              viol_pos;
    logic              first_pending;
    int                order;

    out_item_t         symbols_due [$];

    // back to the start of a sequence, order untouched
    function automatic void restart_line();
        for (int i = 0; i < MAX_ORDER; i++)
            line_q[i] = SYM_ZERO;
        held          = 0;
        zero_run      = '0;
        mark_pos      = 1'b1;
        viol_pos      = 1'b0;
        first_pending = 1'b1;
    endfunction

    function automatic int clamp_order(input logic [ORDER_W-1:0] v);
        int r;
        r = int'(v);
        if (r < int'(ORDER_MIN))
            r = int'(ORDER_MIN);
        if (r > MAX_ORDER)
            r = MAX_ORDER;
        return r;
    endfunction

    // encode one accepted word and queue the symbols it releases
    function automatic void encode_word(input in_item_t w);
        sym_t      cur;
        sym_t      balance;
        out_item_t o;
        int        k;
        int        count;
        int        n;

        n = order;
        if (w.action == ACT_FLUSH)
        begin
            k = held;
            for (int i = 0; i < k; i++)
            begin
                o.symbol = line_q[i];
                o.last   = (i == k - 1);
                symbols_due.push_back(o);
            end
            restart_line();
            return;
        end

        // mark alternation, first one of a sequence is +1 and keeps polarity
        if (first_pending && w.data_bit)
            cur = SYM_POS;
        else if (!w.data_bit)
        begin
            if (zero_run != ZRUN_MAX)
                zero_run = zero_run + 1'b1;
            cur = SYM_ZERO;
        end
        else
        begin
            zero_run = '0;
            cur      = mark_pos ? SYM_NEG : SYM_POS;
            mark_pos = !mark_pos;
        end
        first_pending = 1'b0;

        // zero-run substitution with optional balancing pulse n back
        if (int'(zero_run) >= n + 1)
        begin
            balance = SYM_ZERO;
            if (!viol_pos)
            begin
                if (!mark_pos)
                    balance = SYM_POS;
                cur      = SYM_POS;
                mark_pos = 1'b1;
                viol_pos = 1'b1;
            end
            else
            begin
                if (mark_pos)
                    balance = SYM_NEG;
                cur      = SYM_NEG;
                mark_pos = 1'b0;
                viol_pos = 1'b0;
            end
            if (balance != SYM_ZERO && held >= n && held - n < MAX_ORDER)
                line_q[held - n] = balance;
            zero_run = '0;
        end

        // release the oldest symbols, then append the new one
        count = 0;
        while (held >= n && held > 0 && count < MAX_ORDER)
        begin
            o.symbol = line_q[0];
            o.last   = 1'b0;
            symbols_due.push_back(o);
            count++;
            for (int i = 0; i < MAX_ORDER - 1; i++)
                line_q[i] = line_q[i + 1];
            line_q[MAX_ORDER - 1] = SYM_ZERO;
            held--;
        end
        if (held < MAX_ORDER)
        begin
            line_q[held] = cur;
            held++;
        end
    endfunction

    // output compare first: a word leaving now can't stem from this edge's input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_line();
            order = int'(ORDER_RESET);
            symbols_due.delete();
            err_count = 0;
            due_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (symbols_due.size() == 0)
                begin
                    $error("out word with no symbol due: symbol %0d last %0b",
                           out_data.symbol, out_data.last);
                    err_count++;
                end
                else
                begin
                    if (out_data.symbol !== symbols_due[0].symbol)
                    begin
                        $error("symbol: expected %0d, actual %0d",
                               symbols_due[0].symbol, out_data.symbol);
                        err_count++;
                    end
                    if (out_data.last !== symbols_due[0].last)
                    begin
                        $error("last: expected %0b, actual %0b",
                               symbols_due[0].last, out_data.last);
                        err_count++;
                    end
                    void'(symbols_due.pop_front());
                end
            end
            if (cfg_valid && cfg_ready)
                order = clamp_order(cfg_data);
            if (in_valid && in_ready)
                encode_word(in_data);
            due_count <= symbols_due.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import hdbn_pkg::*;

    localparam int SETTLE     = 16;
    localparam int STALL_MAX  = 2000;
    localparam int HOLD_LEN   = 64;
    localparam int PHASE_LEN  = 17;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [ORDER_W-1:0] cfg_data;

    int err_count;
    int due_count;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;
    logic hold_req;
    logic hold_done;
    int quiet_cycles = 0;

    hdbn_line_encoder u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    hdbn_checker u_chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .err_count (err_count),
        .due_count (due_count)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // offer one word and hold it until taken
    task automatic offer_word(input logic act, input logic din);
        in_valid      <= 1'b1;
        in_data.action   <= act;
        in_data.data_bit <= din;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // random sender gap after a word
    task automatic idle_sender();
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending until every due symbol is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    // order write only with the block idle
    task automatic write_order(input logic [ORDER_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(input logic act, input logic din);
        offer_word(act, din);
        idle_sender();
    endtask

    // receiver: random stalls, or a long counted hold-off when asked
    initial
    begin
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("hdbn_line_encoder: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int   zeros_left;
        int   mode;
        logic [ORDER_W-1:0] ord;

        zeros_left   = 0;
        hold_req     = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset order, empty flush, first mark, alternation, violations
        send(ACT_FLUSH, 1'b1);
        send(ACT_DATA, 1'b1);
        send(ACT_DATA, 1'b1);
        send(ACT_DATA, 1'b1);
        repeat (4) send(ACT_DATA, 1'b0);
        send(ACT_DATA, 1'b1);
        repeat (5) send(ACT_DATA, 1'b0);
        send(ACT_FLUSH, 1'b0);

        // above range clamps to the top order, build a long zero run
        write_order(4'd15);
        send(ACT_DATA, 1'b1);
        repeat (5) send(ACT_DATA, 1'b0);
        // drop to the bottom mid-sequence: surplus release and late substitution
        write_order(4'd0);
        send(ACT_DATA, 1'b0);
        write_order(4'd1);
        send(ACT_DATA, 1'b1);
        // raise mid-sequence, then flush a partly filled line
        write_order(4'd9);
        repeat (3) send(ACT_DATA, 1'b0);
        send(ACT_FLUSH, 1'b1);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 6; ph++)
        begin
            mode = ph % 4;
            if (ph == 0)
                ord = 4'd8;
            else if (ph == 1)
                ord = 4'd2;
            else
                ord = 4'($urandom_range(0, 15));
            write_order(ord);
            tx_idle_pct  = (mode == 1) ? 62 : (mode == 3) ? 18 : 0;
            rx_stall_pct = (mode == 2) ? 62 : (mode == 3) ? 18 : 0;
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if (ph == 0 && i == 4)
                    hold_req = 1'b1;
                if (ph == 2 && i == PHASE_LEN / 2)
                    wait_drained();
                if ($urandom_range(19) == 0)
                    send(ACT_FLUSH, 1'($urandom_range(1)));
                else if (zeros_left > 0)
                begin
                    zeros_left--;
                    send(ACT_DATA, 1'b0);
                end
                else if ($urandom_range(15) == 0)
                    send(ACT_DATA, 1'($urandom_range(1)));
                else if ($urandom_range(2) == 0)
                begin
                    zeros_left = $urandom_range(0, 9);
                    send(ACT_DATA, 1'b0);
                end
                else
                    send(ACT_DATA, 1'b1);
            end
        end

        // drain the line and finish
        send(ACT_FLUSH, 1'b0);
        rx_stall_pct = 0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (err_count == 0 && due_count == 0)
            $display("hdbn_line_encoder: match");
        else
            $display("hdbn_line_encoder: mismatch");
        $finish;
    end

endmodule
